// ----- src/dbmz_pkg.sv -----
package dbmz_pkg;

   // Matrix geometry and bound width.
   localparam int DIM        = 16;
   localparam int IDX_BITS   = 4;
   localparam int ADDR_BITS  = 2 * IDX_BITS;
   localparam int DIM_BITS   = 5;
   localparam int VALUE_BITS = 32;

   typedef logic [IDX_BITS-1:0]  idx_type;
   typedef logic [ADDR_BITS-1:0] addr_type;

   typedef struct packed {
      logic                         inf;
      logic                         strict;
      logic signed [VALUE_BITS-1:0] value;
   } bound_type;

   localparam bound_type BND_ZERO = '{inf: 1'b0, strict: 1'b0, value: '0};
   localparam bound_type BND_NEG1 = '{inf: 1'b0, strict: 1'b0, value: '1};
   localparam bound_type BND_INF  = '{inf: 1'b1, strict: 1'b1, value: '0};

   typedef enum logic [2:0] {
      KIND_WRITE    = 3'd0,
      KIND_READ     = 3'd1,
      KIND_CLOSE    = 3'd2,
      KIND_FUTURE   = 3'd3,
      KIND_PAST     = 3'd4,
      KIND_RESTRICT = 3'd5,
      KIND_EMPTY    = 3'd6,
      KIND_SAT      = 3'd7
   } kind_type;

   typedef struct packed {
      logic [2:0]         kind;
      idx_type            clock_a;
      idx_type            clock_b;
      logic signed [31:0] bound_value;
      logic               bound_strict;
      logic               bound_infinite;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] read_value;
      logic               read_strict;
      logic               read_infinite;
      logic               test_result;
   } rsp_item_type;

   typedef enum logic [2:0] {
      WSEL_SUM,
      WSEL_G,
      WSEL_INF,
      WSEL_NEG1,
      WSEL_ACC
   } wsel_type;

   // Controller states.
   typedef enum logic [4:0] {
      ST_IDLE, ST_START, ST_RD_WAIT, ST_FUT, ST_PST_INIT, ST_PST_RD, ST_PST_CMP,
      ST_PST_WR, ST_RS_B, ST_RS_C, ST_RL_A, ST_RL_B, ST_RL_C, ST_RL_EV,
      ST_EM_0A, ST_EM_0E, ST_EM_A, ST_EM_B, ST_EM_C, ST_EM_EV,
      ST_SAT_A, ST_SAT_EV, ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic     load_g;
      logic     clr_rsp;
      logic     cap_rsp;
      logic     set_tr;
      logic     rd_en;
      addr_type rd_addr;
      logic     cap_a;
      logic     cap_b;
      logic     b_load_g;
      logic     b_load_zero;
      logic     cmp_zero;
      logic     acc_init;
      logic     acc_upd;
      logic     wr_en;
      addr_type wr_addr;
      wsel_type wr_sel;
   } cmd_type;

   // Comparison results from the datapath.
   typedef struct packed {
      logic less;
      logic less_g;
   } status_type;

   // Standard bound order: infinity greatest, strict below non-strict on a tie.
   function automatic logic bnd_lt(bound_type a, bound_type b);
      logic r;
      if (a.inf) begin
         r = 1'b0;
      end else if (b.inf) begin
         r = 1'b1;
      end else if (a.value != b.value) begin
         r = $signed(a.value) < $signed(b.value);
      end else begin
         r = a.strict && !b.strict;
      end
      return r;
   endfunction

   // Bound sum with saturation of finite values.
   function automatic bound_type bnd_add(bound_type a, bound_type b);
      logic signed [VALUE_BITS:0] s;
      bound_type r;
      s = {a.value[VALUE_BITS-1], a.value} + {b.value[VALUE_BITS-1], b.value};
      if (a.inf || b.inf) begin
         r = BND_INF;
      end else begin
         r.inf    = 1'b0;
         r.strict = a.strict | b.strict;
         if (s[VALUE_BITS] != s[VALUE_BITS-1]) begin
            r.value = s[VALUE_BITS] ? {1'b1, {(VALUE_BITS-1){1'b0}}}
                                    : {1'b0, {(VALUE_BITS-1){1'b1}}};
         end else begin
            r.value = s[VALUE_BITS-1:0];
         end
      end
      return r;
   endfunction

endpackage

// ----- src/dbmz_datapath.sv -----
module dbmz_datapath (
   input  logic                  clock,
   input  dbmz_pkg::req_item_type req_item,
   input  dbmz_pkg::cmd_type      cmd,
   output dbmz_pkg::status_type   status,
   output dbmz_pkg::rsp_item_type rsp_item
);
   import dbmz_pkg::*;

   bound_type mem [DIM*DIM];
   bound_type rdata_ff;
   bound_type g_ff, g_in;
   bound_type a_ff, b_ff, acc_ff;
   rsp_item_type rsp_ff;
   bound_type sum, rhs, wdata;

   // Bound of the accepted item, infinite bounds in canonical form.
   always_comb begin
      if (req_item.bound_infinite) begin
         g_in = BND_INF;
      end else begin
         g_in.inf    = 1'b0;
         g_in.strict = req_item.bound_strict;
         g_in.value  = req_item.bound_value;
      end
   end

   // Matrix memory with registered read.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= wdata;
      end
      if (cmd.rd_en) begin
         rdata_ff <= mem[cmd.rd_addr];
      end
   end

   // Sum and comparisons.
   always_comb begin
      sum           = bnd_add(a_ff, b_ff);
      rhs           = cmd.cmp_zero ? BND_ZERO : rdata_ff;
      status.less   = bnd_lt(sum, rhs);
      status.less_g = bnd_lt(g_ff, rdata_ff);
   end

   // Write data selection.
   always_comb begin
      unique case (cmd.wr_sel)
         WSEL_SUM:  wdata = sum;
         WSEL_G:    wdata = g_ff;
         WSEL_INF:  wdata = BND_INF;
         WSEL_NEG1: wdata = BND_NEG1;
         WSEL_ACC:  wdata = acc_ff;
         default:   wdata = sum;
      endcase
   end

   // Operand, accumulator and result registers.
   always_ff @(posedge clock) begin
      if (cmd.load_g) begin
         g_ff <= g_in;
      end
      if (cmd.cap_a) begin
         a_ff <= rdata_ff;
      end
      if (cmd.cap_b) begin
         b_ff <= rdata_ff;
      end else if (cmd.b_load_g) begin
         b_ff <= g_ff;
      end else if (cmd.b_load_zero) begin
         b_ff <= BND_ZERO;
      end
      if (cmd.acc_init) begin
         acc_ff <= BND_ZERO;
      end else if (cmd.acc_upd && bnd_lt(rdata_ff, acc_ff)) begin
         acc_ff <= rdata_ff;
      end
      if (cmd.clr_rsp) begin
         rsp_ff <= '0;
      end else begin
         if (cmd.cap_rsp) begin
            rsp_ff.read_value    <= 32'(rdata_ff.value);
            rsp_ff.read_strict   <= rdata_ff.strict;
            rsp_ff.read_infinite <= rdata_ff.inf;
         end
         if (cmd.set_tr) begin
            rsp_ff.test_result <= 1'b1;
         end
      end
   end

   assign rsp_item = rsp_ff;

endmodule

// ----- src/dbmz_controller.sv -----
module dbmz_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  dbmz_pkg::req_item_type req_item,
   input  logic [4:0]             clocks_in_use,
   input  dbmz_pkg::status_type   status,
   output logic                   busy,
   output logic                   rsp_valid,
   output dbmz_pkg::cmd_type      cmd
);
   import dbmz_pkg::*;

   state_type state_ff, state_in;
   kind_type  kind_ff, kind_in;
   idx_type   a_ff, a_in, b_ff, b_in;
   idx_type   i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic      via_ff, via_in;
   logic [DIM_BITS-1:0] n_eff;
   idx_type   n_m1, v;
   logic      ok, i_last, j_last, k_last;

   // Dimension in use, clamped to the range from one to the matrix size.
   always_comb begin
      if (clocks_in_use == '0) begin
         n_eff = DIM_BITS'(1);
      end else if (clocks_in_use > DIM_BITS'(DIM)) begin
         n_eff = DIM_BITS'(DIM);
      end else begin
         n_eff = clocks_in_use;
      end
      n_m1   = IDX_BITS'(n_eff - DIM_BITS'(1));
      ok     = (a_ff <= n_m1) && (b_ff <= n_m1);
      i_last = (i_ff == n_m1);
      j_last = (j_ff == n_m1);
      k_last = (k_ff == n_m1);
      v      = (kind_ff == KIND_CLOSE) ? k_ff : (via_ff ? b_ff : a_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      kind_ff <= kind_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      k_ff    <= k_in;
      via_ff  <= via_in;
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      via_in    = via_ff;
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               kind_in     = kind_type'(req_item.kind);
               a_in        = req_item.clock_a;
               b_in        = req_item.clock_b;
               cmd.load_g  = 1'b1;
               cmd.clr_rsp = 1'b1;
               state_in    = ST_START;
            end
         end
         ST_START: begin
            i_in   = '0;
            j_in   = '0;
            k_in   = '0;
            via_in = 1'b0;
            unique case (kind_ff)
               KIND_WRITE: begin
                  cmd.wr_en   = ok;
                  cmd.wr_addr = {a_ff, b_ff};
                  cmd.wr_sel  = WSEL_G;
                  state_in    = ST_DONE;
               end
               KIND_READ: begin
                  cmd.rd_en   = ok;
                  cmd.rd_addr = {a_ff, b_ff};
                  state_in    = ok ? ST_RD_WAIT : ST_DONE;
               end
               KIND_CLOSE: begin
                  state_in = ST_RL_A;
               end
               KIND_FUTURE: begin
                  i_in     = IDX_BITS'(1);
                  state_in = (n_m1 == '0) ? ST_DONE : ST_FUT;
               end
               KIND_PAST: begin
                  i_in     = IDX_BITS'(1);
                  state_in = (n_m1 == '0) ? ST_DONE : ST_PST_INIT;
               end
               KIND_RESTRICT: begin
                  cmd.rd_en    = ok;
                  cmd.rd_addr  = {b_ff, a_ff};
                  cmd.b_load_g = 1'b1;
                  state_in     = ok ? ST_RS_B : ST_DONE;
               end
               KIND_EMPTY: begin
                  cmd.rd_en       = 1'b1;
                  cmd.rd_addr     = '0;
                  cmd.b_load_zero = 1'b1;
                  state_in        = ST_EM_0A;
               end
               KIND_SAT: begin
                  cmd.rd_en    = ok;
                  cmd.rd_addr  = {b_ff, a_ff};
                  cmd.b_load_g = 1'b1;
                  state_in     = ok ? ST_SAT_A : ST_DONE;
               end
               default: state_in = ST_DONE;
            endcase
         end
         ST_RD_WAIT: begin
            cmd.cap_rsp = 1'b1;
            state_in    = ST_DONE;
         end
         ST_FUT: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = {i_ff, IDX_BITS'(0)};
            cmd.wr_sel  = WSEL_INF;
            i_in        = i_ff + IDX_BITS'(1);
            state_in    = i_last ? ST_DONE : ST_FUT;
         end
         // Past: column minimum over rows from one, starting at non-strict zero.
         ST_PST_INIT: begin
            cmd.acc_init = 1'b1;
            j_in         = IDX_BITS'(1);
            state_in     = ST_PST_RD;
         end
         ST_PST_RD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = {j_ff, i_ff};
            state_in    = ST_PST_CMP;
         end
         ST_PST_CMP: begin
            cmd.acc_upd = 1'b1;
            j_in        = j_ff + IDX_BITS'(1);
            state_in    = j_last ? ST_PST_WR : ST_PST_RD;
         end
         ST_PST_WR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_addr = {IDX_BITS'(0), i_ff};
            cmd.wr_sel  = WSEL_ACC;
            i_in        = i_ff + IDX_BITS'(1);
            state_in    = i_last ? ST_DONE : ST_PST_INIT;
         end
         // Restrict: emptiness check, then tighten and relax.
         ST_RS_B: begin
            cmd.cap_a   = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = {a_ff, b_ff};
            state_in    = ST_RS_C;
         end
         ST_RS_C: begin
            cmd.cmp_zero = 1'b1;
            if (status.less) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_addr = '0;
               cmd.wr_sel  = WSEL_NEG1;
               state_in    = ST_DONE;
            end else if (status.less_g) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_addr = {a_ff, b_ff};
               cmd.wr_sel  = WSEL_G;
               state_in    = ST_RL_A;
            end else begin
               state_in = ST_DONE;
            end
         end
         // Relaxation step m[i][j] = min(m[i][j], m[i][v] + m[v][j]).
         ST_RL_A: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = {i_ff, v};
            state_in    = ST_RL_B;
         end
         ST_RL_B: begin
            cmd.cap_a   = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = {v, j_ff};
            state_in    = ST_RL_C;
         end
         ST_RL_C: begin
            cmd.cap_b   = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = {i_ff, j_ff};
            state_in    = ST_RL_EV;
         end
         ST_RL_EV: begin
            cmd.wr_en   = status.less;
            cmd.wr_addr = {i_ff, j_ff};
            cmd.wr_sel  = WSEL_SUM;
            state_in    = ST_RL_A;
            if (kind_ff == KIND_RESTRICT && !via_ff) begin
               via_in = 1'b1;
            end else begin
               via_in = 1'b0;
               j_in   = j_last ? '0 : j_ff + IDX_BITS'(1);
               if (j_last) begin
                  i_in = i_last ? '0 : i_ff + IDX_BITS'(1);
                  if (i_last) begin
                     k_in = k_ff + IDX_BITS'(1);
                     if (kind_ff != KIND_CLOSE || k_last) begin
                        state_in = ST_DONE;
                     end
                  end
               end
            end
         end
         // Emptiness test: corner entry, then every pair sum.
         ST_EM_0A: begin
            cmd.cap_a = 1'b1;
            state_in  = ST_EM_0E;
         end
         ST_EM_0E: begin
            cmd.cmp_zero = 1'b1;
            cmd.set_tr   = status.less;
            state_in     = status.less ? ST_DONE : ST_EM_A;
         end
         ST_EM_A: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = {i_ff, j_ff};
            state_in    = ST_EM_B;
         end
         ST_EM_B: begin
            cmd.cap_a   = 1'b1;
            cmd.rd_en   = 1'b1;
            cmd.rd_addr = {j_ff, i_ff};
            state_in    = ST_EM_C;
         end
         ST_EM_C: begin
            cmd.cap_b = 1'b1;
            state_in  = ST_EM_EV;
         end
         ST_EM_EV: begin
            cmd.cmp_zero = 1'b1;
            cmd.set_tr   = status.less;
            j_in         = j_last ? '0 : j_ff + IDX_BITS'(1);
            if (j_last) begin
               i_in = i_ff + IDX_BITS'(1);
            end
            state_in = (status.less || (i_last && j_last)) ? ST_DONE : ST_EM_A;
         end
         ST_SAT_A: begin
            cmd.cap_a = 1'b1;
            state_in  = ST_SAT_EV;
         end
         ST_SAT_EV: begin
            cmd.cmp_zero = 1'b1;
            cmd.set_tr   = !status.less;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ----- src/dbm_zone_engine_core.sv -----
// Zone engine over a 16 by 16 difference bound matrix held in one memory with a
// single registered read port. An item is taken when start is high and busy is
// low; its one result appears for a single cycle with rsp_valid, and the
// receiver must take it then. The run time of an item is set by that read port,
// at most one entry read per cycle; no new item is taken until the result is out.
module dbm_zone_engine_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  dbmz_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   output dbmz_pkg::rsp_item_type rsp_item,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [2:0]             csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);
   import dbmz_pkg::*;

   logic [4:0] clocks_in_use_ff;
   cmd_type    cmd;
   status_type status;

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         clocks_in_use_ff <= 5'd1;
      end else if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
         clocks_in_use_ff <= csr_pwdata[4:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {27'd0, clocks_in_use_ff};

   dbmz_controller u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_item      (req_item),
      .clocks_in_use (clocks_in_use_ff),
      .status        (status),
      .busy          (busy),
      .rsp_valid     (rsp_valid),
      .cmd           (cmd)
   );

   dbmz_datapath u_dp (
      .clock    (clock),
      .req_item (req_item),
      .cmd      (cmd),
      .status   (status),
      .rsp_item (rsp_item)
   );

`ifndef SYNTHESIS
   // An accepted item makes the block busy.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   // A result lasts one cycle.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result held for more than one cycle");

   // A result belongs to an item in progress.
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result shown while idle");
`endif

endmodule

// ----- verif/dbmz_checker.sv -----
`timescale 1ns / 1ps

// Watches the item and result channels and the register port of the zone engine,
// keeps its own copy of the matrix and predicts every result in order.
module dbmz_checker
   import dbmz_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         busy,
   input  req_item_type req_item,
   input  logic         rsp_valid,
   input  rsp_item_type rsp_item,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   input  logic         csr_pready,
   output int           fail_count,
   output int           pending
);

   localparam logic [2:0] ADDR_CLOCKS_IN_USE = 3'd0;

   bound_type    zone [DIM][DIM];
   logic [4:0]   dim_reg;
   rsp_item_type expected_rsp_q [$];

   // Ordering of bounds: infinity on top, strict below non-strict on equal values.
   function automatic logic is_below(bound_type x, bound_type y);
      if (x.inf) return 1'b0;
      if (y.inf) return 1'b1;
      if (x.value != y.value) return x.value < y.value;
      return x.strict && !y.strict;
   endfunction

   // Sum of two bounds; finite sums clamp to the signed value range.
   function automatic bound_type bound_plus(bound_type x, bound_type y);
      longint    total;
      bound_type r;
      total = longint'(x.value) + longint'(y.value);
      r = '{inf: 1'b1, strict: 1'b1, value: '0};
      if (!x.inf && !y.inf) begin
         r.inf = 1'b0;
         r.strict = x.strict | y.strict;
         if (total > 64'sd2147483647) begin
            r.value = 32'sh7fffffff;
         end else if (total < -64'sd2147483648) begin
            r.value = 32'sh80000000;
         end else begin
            r.value = total[31:0];
         end
      end
      return r;
   endfunction

   function automatic int used_dim();
      if (dim_reg < 1) return 1;
      if (dim_reg > DIM) return DIM;
      return int'(dim_reg);
   endfunction

   // Applies one item to the local matrix and returns the result it should give.
   function automatic rsp_item_type zone_operation(req_item_type it);
      rsp_item_type r;
      bound_type    g;
      bound_type    nonneg_zero;
      bound_type    s;
      int           n;
      int           a;
      int           b;
      logic         in_range;
      r = '0;
      n = used_dim();
      a = int'(it.clock_a);
      b = int'(it.clock_b);
      in_range = (a < n) && (b < n);
      nonneg_zero = '{inf: 1'b0, strict: 1'b0, value: '0};
      if (it.bound_infinite) begin
         g = '{inf: 1'b1, strict: 1'b1, value: '0};
      end else begin
         g = '{inf: 1'b0, strict: it.bound_strict, value: it.bound_value};
      end
      case (kind_type'(it.kind))
         KIND_WRITE: begin
            if (in_range) zone[a][b] = g;
         end
         KIND_READ: begin
            if (in_range) begin
               r.read_value = zone[a][b].value;
               r.read_strict = zone[a][b].strict;
               r.read_infinite = zone[a][b].inf;
            end
         end
         KIND_CLOSE: begin
            for (int k = 0; k < n; k++)
               for (int i = 0; i < n; i++)
                  for (int j = 0; j < n; j++) begin
                     s = bound_plus(zone[i][k], zone[k][j]);
                     if (is_below(s, zone[i][j])) zone[i][j] = s;
                  end
         end
         KIND_FUTURE: begin
            for (int i = 1; i < n; i++) zone[i][0] = '{inf: 1'b1, strict: 1'b1, value: '0};
         end
         KIND_PAST: begin
            for (int i = 1; i < n; i++) begin
               zone[0][i] = nonneg_zero;
               for (int j = 1; j < n; j++)
                  if (is_below(zone[j][i], zone[0][i])) zone[0][i] = zone[j][i];
            end
         end
         KIND_RESTRICT: begin
            if (in_range) begin
               if (is_below(bound_plus(zone[b][a], g), nonneg_zero)) begin
                  zone[0][0] = '{inf: 1'b0, strict: 1'b0, value: -32'sd1};
               end else if (is_below(g, zone[a][b])) begin
                  zone[a][b] = g;
                  for (int i = 0; i < n; i++)
                     for (int j = 0; j < n; j++) begin
                        s = bound_plus(zone[i][a], zone[a][j]);
                        if (is_below(s, zone[i][j])) zone[i][j] = s;
                        s = bound_plus(zone[i][b], zone[b][j]);
                        if (is_below(s, zone[i][j])) zone[i][j] = s;
                     end
               end
            end
         end
         KIND_EMPTY: begin
            if (is_below(zone[0][0], nonneg_zero)) r.test_result = 1'b1;
            for (int i = 0; i < n; i++)
               for (int j = 0; j < n; j++)
                  if (is_below(bound_plus(zone[i][j], zone[j][i]), nonneg_zero))
                     r.test_result = 1'b1;
         end
         default: begin
            if (in_range)
               r.test_result = !is_below(bound_plus(zone[b][a], g), nonneg_zero);
         end
      endcase
      return r;
   endfunction

   // Sample both channels and the register port at each rising edge.
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         dim_reg = 5'd1;
         expected_rsp_q.delete();
         fail_count = 0;
         for (int i = 0; i < DIM; i++)
            for (int j = 0; j < DIM; j++) zone[i][j] = '0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr == ADDR_CLOCKS_IN_USE)
            dim_reg = csr_pwdata[4:0];
         if (rsp_valid) begin
            if (expected_rsp_q.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_item);
               fail_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               if (want.read_value !== rsp_item.read_value) begin
                  $display("%0t: read_value expected %0d actual %0d", $time,
                           want.read_value, rsp_item.read_value);
                  fail_count++;
               end
               if (want.read_strict !== rsp_item.read_strict) begin
                  $display("%0t: read_strict expected %b actual %b", $time,
                           want.read_strict, rsp_item.read_strict);
                  fail_count++;
               end
               if (want.read_infinite !== rsp_item.read_infinite) begin
                  $display("%0t: read_infinite expected %b actual %b", $time,
                           want.read_infinite, rsp_item.read_infinite);
                  fail_count++;
               end
               if (want.test_result !== rsp_item.test_result) begin
                  $display("%0t: test_result expected %b actual %b", $time,
                           want.test_result, rsp_item.test_result);
                  fail_count++;
               end
            end
         end
         if (start && !busy) expected_rsp_q.push_back(zone_operation(req_item));
      end
      pending = expected_rsp_q.size();
   end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import dbmz_pkg::*;

   localparam int          CYCLE_LIMIT        = 3000000;
   localparam logic [2:0]  ADDR_CLOCKS_IN_USE = 3'd0;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_item_type req_item = '0;
   logic         rsp_valid;
   rsp_item_type rsp_item;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [2:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;
   int           fail_count;
   int           pending;
   int           cycle_count = 0;
   int           burst_left = 0;
   int           dim_now = 1;
   int           filled_dim = 0;
   bit           written [DIM][DIM];

   dbm_zone_engine_core uut (.*);

   dbmz_checker checker_inst (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Present one item and hold it until it is taken; then either keep the
   // burst going or drop start for a random gap.
   task automatic send_item(kind_type k, int a, int b, int v, bit s, bit inf);
      start <= 1'b1;
      req_item <= '{kind: k, clock_a: a[3:0], clock_b: b[3:0], bound_value: v,
                    bound_strict: s, bound_infinite: inf};
      @(posedge clock);
      while (busy) @(posedge clock);
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(0, 8);
      end else begin
         burst_left--;
      end
   endtask

   // Let every outstanding result arrive before going on.
   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_dimension(logic [4:0] value);
      drain();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_CLOCKS_IN_USE;
      csr_pwdata <= {27'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      dim_now = (value < 1) ? 1 : (value > DIM) ? DIM : int'(value);
   endtask

   // Fill entries in use with a plausible zone so nothing unwritten is read.
   // Without all, only entries beyond the area filled so far are written.
   task automatic fill_zone(bit all);
      for (int i = 0; i < dim_now; i++)
         for (int j = 0; j < dim_now; j++) begin
            if (all || i >= filled_dim || j >= filled_dim) begin
               if (i == j)
                  send_item(KIND_WRITE, i, j, 0, 1'b0, 1'b0);
               else if (i == 0)
                  send_item(KIND_WRITE, i, j, -$urandom_range(0, 10), $urandom_range(1),
                            1'b0);
               else
                  send_item(KIND_WRITE, i, j, $urandom_range(0, 50), $urandom_range(1),
                            $urandom_range(3) == 0);
               written[i][j] = 1'b1;
            end
         end
      if (dim_now > filled_dim) filled_dim = dim_now;
   endtask

   function automatic int pick_value();
      int r;
      r = $urandom_range(19);
      if (r == 0) return 32'sh7fffffff;
      if (r == 1) return 32'sh80000000;
      if (r < 4) return $urandom;
      return $urandom_range(60) - 20;
   endfunction

   function automatic int pick_clock();
      if ($urandom_range(9) == 0) return $urandom_range(15);
      return $urandom_range(dim_now - 1);
   endfunction

   task automatic random_items(int count);
      int r;
      kind_type k;
      for (int t = 0; t < count; t++) begin
         r = $urandom_range(99);
         if (r < 14) k = KIND_WRITE;
         else if (r < 28) k = KIND_READ;
         else if (r < 36) k = (dim_now == DIM && $urandom_range(3) != 0) ? KIND_RESTRICT
                                                                       : KIND_CLOSE;
         else if (r < 43) k = KIND_FUTURE;
         else if (r < 50) k = KIND_PAST;
         else if (r < 75) k = KIND_RESTRICT;
         else if (r < 87) k = KIND_EMPTY;
         else k = KIND_SAT;
         send_item(k, pick_clock(), pick_clock(), pick_value(), $urandom_range(1),
                   $urandom_range(9) == 0);
      end
   endtask

   // On the full matrix: writes, future and reads of entries already written.
   task automatic sparse_items(int count);
      int r;
      int a;
      int b;
      for (int t = 0; t < count; t++) begin
         r = $urandom_range(9);
         a = $urandom_range(dim_now - 1);
         b = $urandom_range(dim_now - 1);
         if (r == 0) begin
            send_item(KIND_FUTURE, 0, 0, 0, 1'b0, 1'b0);
            for (int i = 1; i < dim_now; i++) written[i][0] = 1'b1;
         end else if (r < 6 && written[a][b]) begin
            send_item(KIND_READ, a, b, 0, 1'b0, 1'b0);
         end else begin
            send_item(KIND_WRITE, a, b, pick_value(), $urandom_range(1),
                      $urandom_range(5) == 0);
            written[a][b] = 1'b1;
         end
      end
   endtask

   initial begin
      logic [4:0] phase_dims [6];
      phase_dims = '{5'd0, 5'd16, 5'd4, 5'd31, 5'd2, 5'd6};
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part with the dimension set to 3.
      set_dimension(5'd3);
      fill_zone(1'b1);
      send_item(KIND_WRITE, 1, 2, 32'sh7fffffff, 1'b0, 1'b0);
      send_item(KIND_READ, 1, 2, 0, 1'b0, 1'b0);
      send_item(KIND_WRITE, 2, 1, 32'sh80000000, 1'b1, 1'b0);
      send_item(KIND_READ, 2, 1, 0, 1'b0, 1'b0);
      send_item(KIND_CLOSE, 0, 0, 0, 1'b0, 1'b0);
      send_item(KIND_READ, 1, 1, 0, 1'b0, 1'b0);
      send_item(KIND_WRITE, 0, 1, 5, 1'b1, 1'b1);
      send_item(KIND_READ, 0, 1, 0, 1'b0, 1'b0);
      send_item(KIND_WRITE, 3, 0, 7, 1'b0, 1'b0);
      send_item(KIND_READ, 0, 15, 0, 1'b0, 1'b0);
      send_item(KIND_RESTRICT, 15, 1, -3, 1'b0, 1'b0);
      send_item(KIND_SAT, 1, 9, 0, 1'b0, 1'b0);
      fill_zone(1'b1);
      send_item(KIND_CLOSE, 0, 0, 0, 1'b0, 1'b0);
      send_item(KIND_FUTURE, 0, 0, 0, 1'b0, 1'b0);
      send_item(KIND_PAST, 0, 0, 0, 1'b0, 1'b0);
      send_item(KIND_SAT, 1, 2, 4, 1'b1, 1'b0);
      send_item(KIND_SAT, 2, 1, 0, 1'b0, 1'b1);
      send_item(KIND_RESTRICT, 1, 0, 3, 1'b1, 1'b0);
      send_item(KIND_RESTRICT, 2, 1, 0, 1'b0, 1'b1);
      send_item(KIND_EMPTY, 0, 0, 0, 1'b0, 1'b0);
      send_item(KIND_RESTRICT, 0, 1, -1000, 1'b1, 1'b0);
      send_item(KIND_EMPTY, 0, 0, 0, 1'b0, 1'b0);
      send_item(KIND_READ, 0, 0, 0, 1'b0, 1'b0);

      // Random part over several dimensions, extremes included.
      foreach (phase_dims[p]) begin
         set_dimension(phase_dims[p]);
         if (dim_now == DIM) begin
            sparse_items(10);
         end else begin
            fill_zone(1'b0);
            random_items(7);
            drain();
            random_items(7);
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
